[design/rcd_pkg.sv]
// Shared types, constants and helper functions for the run-length image decoder.
// No dependencies; every other design file imports this package.
package rcd_pkg;

    localparam int MAX_SIDE = 4096;
    localparam int SIDE_W   = 13;
    localparam int POS_W    = 2 * SIDE_W - 1;
    localparam int WORD_W   = 32;
    localparam int MODE_W   = 3;
    localparam int ALPHA_W  = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = SIDE_W;

    localparam logic [MODE_W-1:0] MODE_RAW_KEYED = 3'd0;
    localparam logic [MODE_W-1:0] MODE_RLE_KEYED = 3'd1;
    localparam logic [MODE_W-1:0] MODE_RAW_ALPHA = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_KIND   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd3;

    localparam logic [ALPHA_W-1:0] ALPHA_KIND_FORCE = 8'd3;

    localparam logic [WORD_W-1:0] KEY_COLOUR   = 32'h00ff00ff;
    localparam logic [WORD_W-1:0] COLOUR_MASK  = 32'h00ffffff;
    localparam logic [WORD_W-1:0] ALPHA_OPAQUE = 32'hff000000;
    localparam logic [7:0]        COUNT_ESCAPE = 8'hff;

    typedef struct packed {
        logic [MODE_W-1:0]  image_mode;
        logic [ALPHA_W-1:0] alpha_kind;
        logic [POS_W-1:0]   total;
    } cfg_t;

    function automatic logic [SIDE_W-1:0] side_of(input logic [SIDE_W-1:0] r);
        side_of = (r > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : r;
    endfunction

    function automatic logic [WORD_W-1:0] keyed(input logic [WORD_W-1:0] c);
        keyed = (c != KEY_COLOUR) ? (c | ALPHA_OPAQUE) : c;
    endfunction

endpackage

[design/rcd_word_if.sv]
// Request channel for encoded data words.
// Depends on rcd_pkg for field widths.
interface rcd_word_if
    import rcd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] data_word;
    logic              start_image;

    modport source (output valid, output data_word, output start_image, input ready);
    modport sink   (input valid, input data_word, input start_image, output ready);
endinterface

[design/rcd_run_if.sv]
// Request channel for decoded pixel runs.
// Depends on rcd_pkg for field widths.
interface rcd_run_if
    import rcd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] pixel_value;
    logic [POS_W-1:0]  run_length;
    logic [POS_W-1:0]  start_index;
    logic              last;
    logic              overrun;

    modport source (output valid, output pixel_value, output run_length,
                    output start_index, output last, output overrun, input ready);
    modport sink   (input valid, input pixel_value, input run_length,
                    input start_index, input last, input overrun, output ready);
endinterface

[design/rcd_config_regs.sv]
// Configuration registers and the precomputed pixel total width*height.
// Depends on rcd_pkg.
module rcd_config_regs
    import rcd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    logic [MODE_W-1:0]  mode_reg,   mode_next;
    logic [ALPHA_W-1:0] alpha_reg,  alpha_next;
    logic [SIDE_W-1:0]  width_reg,  width_next;
    logic [SIDE_W-1:0]  height_reg, height_next;
    logic [POS_W-1:0]   total_reg,  total_next;
    logic [2*SIDE_W-1:0] product;

    always_comb
    begin
        mode_next   = mode_reg;
        alpha_next  = alpha_reg;
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_IMAGE_MODE:   mode_next   = cfg_data[MODE_W-1:0];
                CFG_ALPHA_KIND:   alpha_next  = cfg_data[ALPHA_W-1:0];
                CFG_IMAGE_WIDTH:  width_next  = cfg_data;
                CFG_IMAGE_HEIGHT: height_next = cfg_data;
                default:          mode_next   = mode_reg;
            endcase
        end
        product    = side_of(width_next) * side_of(height_next);
        total_next = product[POS_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_RAW_KEYED;
            alpha_reg  <= '0;
            width_reg  <= SIDE_W'(1);
            height_reg <= SIDE_W'(1);
            total_reg  <= POS_W'(1);
        end
        else
        begin
            mode_reg   <= mode_next;
            alpha_reg  <= alpha_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            total_reg  <= total_next;
        end
    end

    assign cfg.image_mode = mode_reg;
    assign cfg.alpha_kind = alpha_reg;
    assign cfg.total      = total_reg;

endmodule

[design/rle_colorkey_image_decoder.sv]
// Run-length / raw color-keyed image decoder top level.
// A word's run is decoded from the input register and registered in the output register.
// Throughput: one word per cycle unless runs.ready stalls the output; an input register
// and an output register part the channels, and the decode step between them is a single pass.
// Reset (rst_n, async, active low) clears position, extension and done state.
module rle_colorkey_image_decoder
    import rcd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    rcd_word_if.sink              words,
    rcd_run_if.source             runs
);

    cfg_t cfg;

    rcd_config_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    logic              in_valid_reg;
    logic [WORD_W-1:0] in_word_reg;
    logic              in_start_reg;
    logic              advance;

    logic              ext_reg,  ext_next;
    logic [WORD_W-1:0] held_reg, held_next;
    logic [POS_W-1:0]  pos_reg,  pos_next;
    logic              done_reg, done_next;

    logic              out_valid_reg;
    logic [WORD_W-1:0] out_value_reg, out_value_next;
    logic [POS_W-1:0]  out_len_reg,   out_len_next;
    logic [POS_W-1:0]  out_start_reg, out_start_next;
    logic              out_last_reg,  out_last_next;
    logic              out_over_reg,  out_over_next;
    logic              emit;

    logic              run_en;
    logic [WORD_W-1:0] run_value;
    logic [WORD_W-1:0] run_len;
    logic [POS_W-1:0]  rem;
    logic              over;

    assign advance     = in_valid_reg && (!out_valid_reg || runs.ready);
    assign words.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (words.ready)
        begin
            in_valid_reg <= words.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (words.ready && words.valid)
        begin
            in_word_reg  <= words.data_word;
            in_start_reg <= words.start_image;
        end
    end

    always_comb
    begin
        ext_next  = in_start_reg ? 1'b0 : ext_reg;
        held_next = in_start_reg ? '0 : held_reg;
        pos_next  = in_start_reg ? '0 : pos_reg;
        done_next = in_start_reg ? 1'b0 : done_reg;

        run_en    = 1'b0;
        run_value = in_word_reg;
        run_len   = WORD_W'(1);

        emit           = 1'b0;
        out_value_next = '0;
        out_len_next   = '0;
        out_start_next = pos_next;
        out_last_next  = 1'b0;
        out_over_next  = 1'b0;
        rem            = '0;
        over           = 1'b0;

        if (!done_next)
        begin
            unique case (cfg.image_mode)
                MODE_RAW_KEYED:
                begin
                    run_en    = 1'b1;
                    run_value = keyed(in_word_reg);
                end
                MODE_RAW_ALPHA:
                begin
                    run_en    = 1'b1;
                    run_value = in_word_reg |
                                ((cfg.alpha_kind == ALPHA_KIND_FORCE) ? ALPHA_OPAQUE : '0);
                end
                MODE_RLE_KEYED:
                begin
                    priority if (ext_next)
                    begin
                        ext_next = 1'b0;
                        if (!in_word_reg[WORD_W-1])
                        begin
                            run_en    = 1'b1;
                            run_value = held_next;
                            run_len   = in_word_reg + WORD_W'(COUNT_ESCAPE);
                        end
                    end
                    else if (in_word_reg == '0)
                    begin
                        emit          = 1'b1;
                        out_last_next = 1'b1;
                        done_next     = 1'b1;
                    end
                    else if (in_word_reg[WORD_W-1 -: 8] == COUNT_ESCAPE)
                    begin
                        held_next = keyed(in_word_reg & COLOUR_MASK);
                        ext_next  = 1'b1;
                    end
                    else if (in_word_reg[WORD_W-1 -: 8] != 8'd0)
                    begin
                        run_en    = 1'b1;
                        run_value = keyed(in_word_reg & COLOUR_MASK);
                        run_len   = WORD_W'(in_word_reg[WORD_W-1 -: 8]);
                    end
                    else
                    begin
                        run_en = 1'b0;
                    end
                end
                default:
                begin
                    run_en = 1'b0;
                end
            endcase
        end

        if (run_en)
        begin
            emit           = 1'b1;
            out_value_next = run_value;
            if (pos_next >= cfg.total)
            begin
                out_last_next = 1'b1;
                out_over_next = 1'b1;
                done_next     = 1'b1;
            end
            else
            begin
                rem           = cfg.total - pos_next;
                over          = run_len > WORD_W'(rem);
                out_len_next  = over ? rem : run_len[POS_W-1:0];
                out_over_next = over;
                out_last_next = run_len >= WORD_W'(rem);
                done_next     = out_last_next;
                pos_next      = pos_next + out_len_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ext_reg  <= 1'b0;
            held_reg <= '0;
            pos_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (advance)
        begin
            ext_reg  <= ext_next;
            held_reg <= held_next;
            pos_reg  <= pos_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= emit;
        end
        else if (runs.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            out_value_reg <= out_value_next;
            out_len_reg   <= out_len_next;
            out_start_reg <= out_start_next;
            out_last_reg  <= out_last_next;
            out_over_reg  <= out_over_next;
        end
    end

    assign runs.valid       = out_valid_reg;
    assign runs.pixel_value = out_value_reg;
    assign runs.run_length  = out_len_reg;
    assign runs.start_index = out_start_reg;
    assign runs.last        = out_last_reg;
    assign runs.overrun     = out_over_reg;

endmodule
